// File: sv/analog_stick_deadzone_calibration_defines.svh
// Assertion macros for the analog stick deadzone calibration block.
`ifndef ANALOG_STICK_DEADZONE_CALIBRATION_DEFINES_SVH
`define ANALOG_STICK_DEADZONE_CALIBRATION_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ASDC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/asdc_pkg.sv
// Types and constants shared by the analog stick deadzone calibration block.
package asdc_pkg;

  localparam int AXES       = 4;
  localparam int NUM_W      = 15;
  localparam int DIV_STEPS  = 15;
  localparam int CNT_W      = 4;
  localparam int GAIN_SHIFT = 7;
  localparam int CFG_IDX_W  = 2;

  localparam logic [7:0]  REST  = 8'd127;
  localparam logic [7:0]  FULL  = 8'd255;

  localparam logic [NUM_W-1:0] UPPER_NUM = 15'h4000;
  localparam logic [NUM_W-1:0] LOWER_NUM = 15'h3f80;

  localparam logic [7:0]  UPPER_RST = 8'd175;
  localparam logic [7:0]  LOWER_RST = 8'd79;
  localparam logic [14:0] UGAIN_RST = 15'd204;
  localparam logic [13:0] LGAIN_RST = 14'd205;

  localparam logic [7:0]  MIN_RST = 8'd0;
  localparam logic [7:0]  MAX_RST = 8'd255;
  localparam logic [6:0]  DZ_RST  = 7'd48;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE  = 2'd2;

  localparam logic MODE_APPLY   = 1'b0;
  localparam logic MODE_CAPTURE = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] axis_0;
    logic [7:0] axis_1;
    logic [7:0] axis_2;
    logic [7:0] axis_3;
  } sample_t;

  typedef struct packed {
    logic [7:0] out_0;
    logic [7:0] out_1;
    logic [7:0] out_2;
    logic [7:0] out_3;
    logic       calib_ok;
  } result_t;

  typedef struct packed {
    logic [7:0] min_limit;
    logic [7:0] max_limit;
    logic [6:0] deadzone;
  } cal_cfg_t;

  typedef struct packed {
    logic start;
    logic ok;
  } lane_ctrl_t;

  typedef struct packed {
    logic pass;
    logic busy;
  } lane_stat_t;

endpackage

// File: sv/asdc_div.sv
// Restoring divider, one quotient bit per cycle, for the gain computation.
module asdc_div
  import asdc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [7:0]       den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  logic [CNT_W-1:0] cnt;
  logic [7:0]       rem;
  logic [NUM_W-1:0] numer;
  logic [7:0]       dvsr;
  logic [8:0]       trial;
  logic [8:0]       trial_diff;
  logic             fits;
  logic [7:0]       rem_next;

  // divide by zero yields all ones, which is the required saturated gain
  always_comb begin
    trial      = {rem, numer[NUM_W-1]};
    trial_diff = trial - {1'b0, dvsr};
    fits       = trial >= {1'b0, dvsr};
    rem_next   = fits ? trial_diff[7:0] : trial[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      numer <= num;
      dvsr  <= den;
      quot  <= '0;
    end else if (busy) begin
      rem   <= rem_next;
      numer <= {numer[NUM_W-2:0], 1'b0};
      quot  <= {quot[NUM_W-2:0], fits};
    end
  end

endmodule

// File: sv/asdc_lane.sv
// One axis lane: center check, threshold and gain store, and the apply mapping.
module asdc_lane
  import asdc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] axis,
  input  cal_cfg_t   cfg,
  input  lane_ctrl_t ctrl,
  output lane_stat_t stat,
  output logic [7:0] mapped
);

  logic [7:0]       upper_threshold;
  logic [7:0]       lower_threshold;
  logic [14:0]      upper_gain;
  logic [13:0]      lower_gain;

  logic [8:0]       hi_sum;
  logic [7:0]       lo_diff;
  logic             hi_ok;
  logic             lo_ok;

  logic [7:0]       center;
  logic [7:0]       span_lo;
  logic [7:0]       span_hi;
  logic [7:0]       up_new;
  logic [7:0]       dn_new;
  logic [7:0]       uspan;
  logic [7:0]       lspan;

  logic             ubusy;
  logic             udone;
  logic             lbusy;
  logic             ldone;
  logic [NUM_W-1:0] uq;
  logic [NUM_W-1:0] lq;

  logic [7:0]       above;
  logic [7:0]       below;
  logic [22:0]      up_prod;
  logic [21:0]      dn_prod;
  logic [22:0]      up_shift;
  logic [21:0]      dn_shift;
  logic [16:0]      up_sum;
  logic [14:0]      dn_dec;

  // center must sit more than a deadzone inside the limits
  always_comb begin
    hi_sum    = {1'b0, axis} + {2'b0, cfg.deadzone};
    lo_diff   = axis - {1'b0, cfg.deadzone};
    hi_ok     = hi_sum < {1'b0, cfg.max_limit};
    lo_ok     = (axis > {1'b0, cfg.deadzone}) && (cfg.min_limit < lo_diff);
    stat.pass = hi_ok && lo_ok;
    stat.busy = ubusy || udone || lbusy || ldone;
  end

  // fallback: center 127 over the full 0..255 range
  always_comb begin
    center  = ctrl.ok ? axis : REST;
    span_lo = ctrl.ok ? cfg.min_limit : 8'd0;
    span_hi = ctrl.ok ? cfg.max_limit : FULL;
    up_new  = center + {1'b0, cfg.deadzone};
    dn_new  = center - {1'b0, cfg.deadzone};
    uspan   = span_hi - up_new;
    lspan   = dn_new - span_lo;
  end

  asdc_div u_upper_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctrl.start),
    .num   (UPPER_NUM),
    .den   (uspan),
    .busy  (ubusy),
    .done  (udone),
    .quot  (uq)
  );

  asdc_div u_lower_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctrl.start),
    .num   (LOWER_NUM),
    .den   (lspan),
    .busy  (lbusy),
    .done  (ldone),
    .quot  (lq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_threshold <= UPPER_RST;
      lower_threshold <= LOWER_RST;
      upper_gain      <= UGAIN_RST;
      lower_gain      <= LGAIN_RST;
    end else begin
      if (ctrl.start) begin
        upper_threshold <= up_new;
        lower_threshold <= dn_new;
      end
      if (udone) begin
        upper_gain <= uq;
      end
      if (ldone) begin
        lower_gain <= lq[13:0];
      end
    end
  end

  always_comb begin
    above    = axis - upper_threshold;
    below    = lower_threshold - axis;
    up_prod  = {15'b0, above} * {8'b0, upper_gain};
    dn_prod  = {14'b0, below} * {8'b0, lower_gain};
    up_shift = up_prod >> GAIN_SHIFT;
    dn_shift = dn_prod >> GAIN_SHIFT;
    up_sum   = {1'b0, up_shift[15:0]} + {9'b0, REST};
    dn_dec   = dn_shift[14:0];
    if (axis > upper_threshold) begin
      mapped = (up_sum > {9'b0, FULL}) ? FULL : up_sum[7:0];
    end else if (axis < lower_threshold) begin
      mapped = (dn_dec > {7'b0, REST}) ? 8'd0 : (REST - dn_dec[7:0]);
    end else begin
      mapped = REST;
    end
  end

endmodule

// File: sv/analog_stick_deadzone_calibration.sv
// Analog stick deadzone calibration top level: config registers, lanes, merge.
//
// Input channel sample (sample_valid/sample_stall) carries a mode bit and
// four raw axis bytes. Mode apply maps every axis through its stored
// thresholds and gains; mode capture takes the bytes as centers and
// recalibrates all axes. Output channel result (result_valid/result_stall)
// carries one transaction per sample: four mapped axes and calib_ok.
// The result is registered: the result register loads at the accepting edge.
// Apply samples run one per cycle while sample_stall is low. A capture sample
// occupies the per-lane gain dividers for its quotient bits plus the gain
// write, during which sample_stall stays high; its result (all axes 127) shows at once.
// A stalled result holds, and a new sample is only taken when the result
// register is empty or being drained in the same cycle.
// Config writes (cfg_valid/cfg_ready, always ready) set min_limit, max_limit
// and deadzone; they act on the next capture. Unknown indexes are ignored.
// Reset empties the result register, loads the default limits and deadzone,
// and the rest-state calibration (thresholds 175/79, gains 204/205).
`include "analog_stick_deadzone_calibration_defines.svh"

module analog_stick_deadzone_calibration
  import asdc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  sample_t              sample,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  cal_cfg_t   cfg;
  lane_ctrl_t ctrl;
  lane_stat_t stat_arr [AXES];
  logic [7:0] axis_arr [AXES];
  logic [7:0] mapped_arr [AXES];
  logic       ok_all;
  logic       busy_any;
  logic       accept;
  result_t    result_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_limit <= MIN_RST;
      cfg.max_limit <= MAX_RST;
      cfg.deadzone  <= DZ_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_LIMIT: cfg.min_limit <= cfg_data;
        CFG_MAX_LIMIT: cfg.max_limit <= cfg_data;
        CFG_DEADZONE:  cfg.deadzone  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    axis_arr[0] = sample.axis_0;
    axis_arr[1] = sample.axis_1;
    axis_arr[2] = sample.axis_2;
    axis_arr[3] = sample.axis_3;
  end

  for (genvar i = 0; i < AXES; i++) begin : g_lane
    asdc_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .axis   (axis_arr[i]),
      .cfg    (cfg),
      .ctrl   (ctrl),
      .stat   (stat_arr[i]),
      .mapped (mapped_arr[i])
    );
  end

  // merge: all lanes must pass, any lane dividing holds off new samples
  always_comb begin
    ok_all   = 1'b1;
    busy_any = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      ok_all   = ok_all && stat_arr[i].pass;
      busy_any = busy_any || stat_arr[i].busy;
    end
  end

  assign sample_stall = busy_any || (result_valid && result_stall);
  assign accept       = sample_valid && !sample_stall;
  assign ctrl.start   = accept && (sample.mode == MODE_CAPTURE);
  assign ctrl.ok      = ok_all;

  always_comb begin
    if (sample.mode == MODE_CAPTURE) begin
      result_next.out_0    = REST;
      result_next.out_1    = REST;
      result_next.out_2    = REST;
      result_next.out_3    = REST;
      result_next.calib_ok = ok_all;
    end else begin
      result_next.out_0    = mapped_arr[0];
      result_next.out_1    = mapped_arr[1];
      result_next.out_2    = mapped_arr[2];
      result_next.out_3    = mapped_arr[3];
      result_next.calib_ok = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  `ASDC_ASSERT_NEXT(a_capture_starts_div, ctrl.start, busy_any, "capture did not start dividers")
  `ASDC_ASSERT_NEXT(a_apply_ok, accept && (sample.mode == MODE_APPLY), result_valid && result.calib_ok, "apply result missing or not ok")
  `ASDC_ASSERT_SAME(a_fail_rest, result_valid && !result.calib_ok, (result.out_0 == REST) && (result.out_3 == REST), "failed capture result not at rest")

endmodule
